// ----- src/rps_pkg.sv -----
// Package with the shared types and constants of the rectangle pair spacing block.
`default_nettype none
package rps_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 4;
    localparam int DIST_BITS  = COORD_BITS + FRAC_BITS + 1;
    // Width of the radicand and of the square root work registers.
    localparam int RAD_BITS   = 2 * COORD_BITS + 1 + 2 * FRAC_BITS;
    localparam int WORK_BITS  = 2 * DIST_BITS + 1;
    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_left;
        logic signed [COORD_BITS-1:0] a_bottom;
        logic signed [COORD_BITS-1:0] a_right;
        logic signed [COORD_BITS-1:0] a_top;
        logic signed [COORD_BITS-1:0] b_left;
        logic signed [COORD_BITS-1:0] b_bottom;
        logic signed [COORD_BITS-1:0] b_right;
        logic signed [COORD_BITS-1:0] b_top;
    } t_in;

    typedef struct packed {
        logic                         overlap_flag;
        logic signed [COORD_BITS-1:0] cut_left;
        logic signed [COORD_BITS-1:0] cut_bottom;
        logic signed [COORD_BITS-1:0] cut_right;
        logic signed [COORD_BITS-1:0] cut_top;
        logic        [DIST_BITS-1:0]  gap_distance;
        logic                         diagonal_case;
    } t_out;

    // Classified pair, as handed from the front to the back.
    typedef struct packed {
        logic                         overlap_flag;
        logic signed [COORD_BITS-1:0] cut_left;
        logic signed [COORD_BITS-1:0] cut_bottom;
        logic signed [COORD_BITS-1:0] cut_right;
        logic signed [COORD_BITS-1:0] cut_top;
        logic                         diagonal_case;
        logic        [COORD_BITS-1:0] dx;
        logic        [COORD_BITS-1:0] dy;
    } t_work;

endpackage
`default_nettype wire

// ----- src/rps_front.sv -----
// Front end: classifies a rectangle pair into overlap, axis gap or diagonal gap.
`default_nettype none
module rps_front (
    input  wire rps_pkg::t_in   i_pair,
    output rps_pkg::t_work      o_work
);

    logic above, below, right, left, ov;
    logic [rps_pkg::COORD_BITS-1:0] gx_r, gx_l, gy_a, gy_b;

    // Direction tests with A as reference.
    assign above = i_pair.a_top < i_pair.b_bottom;
    assign below = i_pair.a_bottom > i_pair.b_top;
    assign right = i_pair.a_right < i_pair.b_left;
    assign left  = i_pair.a_left > i_pair.b_right;
    assign ov    = !(i_pair.b_right < i_pair.a_left || i_pair.b_top < i_pair.a_bottom ||
                     i_pair.a_right < i_pair.b_left || i_pair.a_top < i_pair.b_bottom);

    // Gaps wrap modulo the coordinate width, which gives the unsigned distance.
    assign gx_r = i_pair.b_left - i_pair.a_right;
    assign gx_l = i_pair.a_left - i_pair.b_right;
    assign gy_a = i_pair.b_bottom - i_pair.a_top;
    assign gy_b = i_pair.a_bottom - i_pair.b_top;

    // Select the cut rectangle and the gap components.
    always_comb begin
        o_work = '0;
        o_work.overlap_flag = ov;
        if (ov) begin
            o_work.cut_left   = (i_pair.a_left > i_pair.b_left) ? i_pair.a_left : i_pair.b_left;
            o_work.cut_bottom = (i_pair.a_bottom > i_pair.b_bottom) ?
                                i_pair.a_bottom : i_pair.b_bottom;
            o_work.cut_right  = (i_pair.a_right < i_pair.b_right) ?
                                i_pair.a_right : i_pair.b_right;
            o_work.cut_top    = (i_pair.a_top < i_pair.b_top) ? i_pair.a_top : i_pair.b_top;
        end else if ((above || below) && (right || left)) begin
            // Corner cases: right wins over left, and the vertical choice
            // follows the order in which the corners are tried.
            o_work.diagonal_case = 1'b1;
            if (right) begin
                o_work.dx = gx_r;
                o_work.dy = above ? gy_a : gy_b;
            end else begin
                o_work.dx = gx_l;
                o_work.dy = below ? gy_b : gy_a;
            end
        end else if (right) begin
            o_work.dx = gx_r;
        end else if (below) begin
            o_work.dx = gy_b;
        end else if (left) begin
            o_work.dx = gx_l;
        end else begin
            o_work.dx = gy_a;
        end
    end

endmodule
`default_nettype wire

// ----- src/rps_fifo.sv -----
// Short queue between the front end and the distance pipeline.
`default_nettype none
module rps_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire rps_pkg::t_work i_data,
    output logic                o_full,
    output logic                o_valid,
    output rps_pkg::t_work      o_data
);

    localparam int PW = $clog2(rps_pkg::FIFO_DEPTH);

    rps_pkg::t_work r_mem [rps_pkg::FIFO_DEPTH];
    rps_pkg::t_work r_out;
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          r_out_v;
    logic          pop;

    // The back end never stalls, so an entry leaves in every cycle it is present.
    assign pop     = r_cnt != '0;
    assign o_full  = r_cnt == (PW+1)'(rps_pkg::FIFO_DEPTH);
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // Storage write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (pop) begin
            r_out <= r_mem[r_rp];
        end
    end

    // Pointers, fill count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (pop)    r_rp <= r_rp + 1'b1;
            r_cnt   <= r_cnt + (PW+1)'(i_push) - (PW+1)'(pop);
            r_out_v <= pop;
        end
    end

endmodule
`default_nettype wire

// ----- src/rps_back.sv -----
// Back end: squares, sums and takes a pipelined integer square root.
`default_nettype none
module rps_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire rps_pkg::t_work i_work,
    output logic                o_strobe,
    output rps_pkg::t_out       o_result
);

    localparam int CB = rps_pkg::COORD_BITS;
    localparam int DB = rps_pkg::DIST_BITS;
    localparam int TW = rps_pkg::WORK_BITS;

    // Square stage.
    logic [2*CB-1:0] r_sx, r_sy;
    rps_pkg::t_work  r_w0;
    logic            r_v0;

    // Square root, one result bit per stage, most significant first.
    logic [TW-1:0]  r_rem [DB+1];
    logic [DB-1:0]  r_q   [DB+1];
    rps_pkg::t_work r_pay [DB+1];
    logic [DB:0]    r_v;

    // Squares, then the scaled sum that feeds the first root stage.
    always_ff @(posedge i_clk) begin
        r_sx     <= i_work.dx * i_work.dx;
        r_sy     <= i_work.dy * i_work.dy;
        r_w0     <= i_work;
        r_rem[0] <= (TW'(r_sx) + TW'(r_sy)) << (2 * rps_pkg::FRAC_BITS);
        r_q[0]   <= '0;
        r_pay[0] <= r_w0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v[0] <= 1'b0;
        end else begin
            r_v0   <= i_valid;
            r_v[0] <= r_v0;
        end
    end

    for (genvar k = 0; k < DB; k++) begin : g_root
        localparam int I = DB - 1 - k;
        logic [TW-1:0] trial;
        assign trial = (TW'(r_q[k]) << (I + 1)) + (TW'(1) << (2 * I));

        always_ff @(posedge i_clk) begin
            r_pay[k+1] <= r_pay[k];
            if (r_rem[k] >= trial) begin
                r_rem[k+1] <= r_rem[k] - trial;
                r_q[k+1]   <= r_q[k] | (DB'(1) << I);
            end else begin
                r_rem[k+1] <= r_rem[k];
                r_q[k+1]   <= r_q[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    // Result assembly from the last stage.
    always_comb begin
        o_strobe               = r_v[DB];
        o_result.overlap_flag  = r_pay[DB].overlap_flag;
        o_result.cut_left      = r_pay[DB].cut_left;
        o_result.cut_bottom    = r_pay[DB].cut_bottom;
        o_result.cut_right     = r_pay[DB].cut_right;
        o_result.cut_top       = r_pay[DB].cut_top;
        o_result.diagonal_case = r_pay[DB].diagonal_case;
        o_result.gap_distance  = r_pay[DB].diagonal_case ? r_q[DB] :
                                 (DB'(r_pay[DB].dx) << rps_pkg::FRAC_BITS);
    end

endmodule
`default_nettype wire

// ----- src/rectangle_pair_spacing.sv -----
// Path from start to strobe: queue storage, queue output, squares, scaled sum, then the root stages.
// Throughput: one pair per cycle; the square root is one pipeline stage per result bit.
// The queue drains every cycle, so busy stays low and the receiver cannot stall.
// Reset (synchronous, active low) clears the queue pointers and pipeline valid bits.
// Top level: rectangle overlap, cut rectangle and closest distance.
`default_nettype none
module rectangle_pair_spacing (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    input  wire rps_pkg::t_in i_pair,
    output logic              busy,
    output logic              o_strobe,
    output rps_pkg::t_out     o_result
);

    rps_pkg::t_work front_work, q_work;
    logic           q_valid, push;

    assign push = start && !busy;

    rps_front u_front (
        .i_pair (i_pair),
        .o_work (front_work)
    );

    rps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_work),
        .o_full  (busy),
        .o_valid (q_valid),
        .o_data  (q_work)
    );

    rps_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_work   (q_work),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // The queue drains every cycle, so it never fills.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("queue filled");
    // An overlap reports no distance and no corner case.
    a_overlap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.overlap_flag |-> o_result.gap_distance == '0 &&
        !o_result.diagonal_case)
        else $error("overlap with distance");
    // Without overlap the cut rectangle is all zeros.
    a_cut_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.overlap_flag |-> o_result.cut_left == '0 &&
        o_result.cut_bottom == '0 && o_result.cut_right == '0 && o_result.cut_top == '0)
        else $error("cut rectangle without overlap");

endmodule
`default_nettype wire
